// ----- rtl/acpu_pkg.sv -----
// Shared types and codes for the accumulator CPU step block.
// No dependencies; used by every module in rtl/.
package acpu_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned OPER_W  = 2;

  localparam logic [DATA_W-1:0] BYTE_ONES = 8'hFF;
  localparam logic [DATA_W-1:0] BYTE_ONE  = 8'h01;
  localparam logic [DATA_W-1:0] SP_RESET  = 8'hFF;

  // item operations
  localparam logic [OPER_W-1:0] OPER_EXEC  = 2'd0;
  localparam logic [OPER_W-1:0] OPER_WRITE = 2'd1;
  localparam logic [OPER_W-1:0] OPER_SETPC = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_RUNNING   = 3'd0;
  localparam logic [STAT_W-1:0] ST_HALTED    = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd3;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd4;

  // opcodes
  localparam logic [DATA_W-1:0] OPC_NOP     = 8'd0;
  localparam logic [DATA_W-1:0] OPC_LDA_IMM = 8'd1;
  localparam logic [DATA_W-1:0] OPC_LDA_MEM = 8'd2;
  localparam logic [DATA_W-1:0] OPC_STA     = 8'd3;
  localparam logic [DATA_W-1:0] OPC_LDB_IMM = 8'd4;
  localparam logic [DATA_W-1:0] OPC_ADD     = 8'd5;
  localparam logic [DATA_W-1:0] OPC_SUB     = 8'd6;
  localparam logic [DATA_W-1:0] OPC_JMP     = 8'd7;
  localparam logic [DATA_W-1:0] OPC_JZ      = 8'd8;
  localparam logic [DATA_W-1:0] OPC_CALL    = 8'd9;
  localparam logic [DATA_W-1:0] OPC_RET     = 8'd10;
  localparam logic [DATA_W-1:0] OPC_HALT    = 8'd11;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              cin;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              cout;
    logic              zero;
    logic              neg;
  } alu_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

// ----- rtl/acpu_alu.sv -----
// Shared 8-bit adder with carry in/out and zero/negative detect.
// Depends on acpu_pkg.
module acpu_alu (
  input  acpu_pkg::alu_req_t req,
  output acpu_pkg::alu_res_t res
);

  logic [acpu_pkg::DATA_W:0] full;

  assign full = {1'b0, req.a} + {1'b0, req.b} + {{acpu_pkg::DATA_W{1'b0}}, req.cin};

  assign res.sum  = full[acpu_pkg::DATA_W-1:0];
  assign res.cout = full[acpu_pkg::DATA_W];
  assign res.zero = (full[acpu_pkg::DATA_W-1:0] == '0);
  assign res.neg  = full[acpu_pkg::DATA_W-1];

endmodule

// ----- rtl/acpu_mem.sv -----
// Single-port 256x8 program/stack memory, registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on acpu_pkg.
module acpu_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acpu_pkg::mem_req_t            req,
  output logic [acpu_pkg::DATA_W-1:0]   rdata
);

  logic [acpu_pkg::DATA_W-1:0]    mem [acpu_pkg::MEM_DEPTH];
  logic [acpu_pkg::MEM_DEPTH-1:0] valid_r;
  logic [acpu_pkg::DATA_W-1:0]    rdata_r;
  logic                           rvalid_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end else begin
      rdata_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else if (req.we) begin
      valid_r[req.addr] <= 1'b1;
    end else begin
      rvalid_r <= valid_r[req.addr];
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

// ----- rtl/accumulator_cpu_step.sv -----
// Accumulator CPU step: one memory port and one shared adder under a sequencer.
// An exec step reads the opcode, then any operand, then the addressed byte for
// load-from-memory or the stack top for return, and ends in finish; a write, set-pc
// or halted step goes straight to finish. Memory reads are registered. No new item
// is accepted until the result loads; the load waits while the output is stalled.
// Synchronous active-low reset; memory reads as zero after reset with no clear pass.
module accumulator_cpu_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [acpu_pkg::OPER_W-1:0]   in_operation,
  input  logic [acpu_pkg::ADDR_W-1:0]   in_address,
  input  logic [acpu_pkg::DATA_W-1:0]   in_write_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [acpu_pkg::STAT_W-1:0]   out_status,
  output logic [acpu_pkg::DATA_W-1:0]   out_prog_counter,
  output logic [acpu_pkg::DATA_W-1:0]   out_accumulator,
  output logic [acpu_pkg::DATA_W-1:0]   out_b_register,
  output logic [acpu_pkg::DATA_W-1:0]   out_stack_pointer,
  output logic                          out_zero_flag,
  output logic                          out_carry_flag,
  output logic                          out_negative_flag
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OPC  = 3'd1;
  localparam logic [2:0] S_ARG  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [acpu_pkg::DATA_W-1:0] pc_r, pc_nxt, acc_r, acc_nxt, b_r, b_nxt, sp_r, sp_nxt;
  logic [acpu_pkg::DATA_W-1:0] opc_r, opc_nxt;
  logic z_r, z_nxt, c_r, c_nxt, n_r, n_nxt, halted_r, halted_nxt;
  logic [acpu_pkg::STAT_W-1:0] status_r, status_nxt;
  logic out_valid_r, out_valid_nxt, load_out;

  logic [acpu_pkg::STAT_W-1:0] ostat_r;
  logic [acpu_pkg::DATA_W-1:0] opc_out_r, oacc_r, ob_r, osp_r;
  logic oz_r, oc_r, on_r;

  acpu_pkg::alu_req_t alu_req;
  acpu_pkg::alu_res_t alu_res;
  acpu_pkg::mem_req_t mem_req;
  logic [acpu_pkg::DATA_W-1:0] rdata;
  logic in_accept, needs_arg;

  acpu_alu u_alu (.req(alu_req), .res(alu_res));

  acpu_mem u_mem (.clk(clk), .rst_n(rst_n), .req(mem_req), .rdata(rdata));

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign needs_arg = (rdata == acpu_pkg::OPC_LDA_IMM) || (rdata == acpu_pkg::OPC_LDA_MEM) ||
                     (rdata == acpu_pkg::OPC_STA) || (rdata == acpu_pkg::OPC_LDB_IMM) ||
                     (rdata == acpu_pkg::OPC_JMP) || (rdata == acpu_pkg::OPC_JZ) ||
                     (rdata == acpu_pkg::OPC_CALL);

  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    acc_nxt    = acc_r;
    b_nxt      = b_r;
    sp_nxt     = sp_r;
    opc_nxt    = opc_r;
    z_nxt      = z_r;
    c_nxt      = c_r;
    n_nxt      = n_r;
    halted_nxt = halted_r;
    status_nxt = status_r;
    load_out   = 1'b0;
    alu_req    = '{a: pc_r, b: acpu_pkg::BYTE_ONE, cin: 1'b0};
    mem_req    = '{we: 1'b0, addr: pc_r, wdata: acc_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          status_nxt = halted_r ? acpu_pkg::ST_HALTED : acpu_pkg::ST_RUNNING;
          state_nxt  = S_FIN;
          unique case (in_operation)
            acpu_pkg::OPER_EXEC: begin
              if (!halted_r) begin
                // opcode fetch
                pc_nxt    = alu_res.sum;
                state_nxt = S_OPC;
              end
            end
            acpu_pkg::OPER_WRITE: begin
              mem_req = '{we: 1'b1, addr: in_address, wdata: in_write_data};
            end
            acpu_pkg::OPER_SETPC: pc_nxt = in_address;
            default: ;
          endcase
        end
      end
      S_OPC: begin
        opc_nxt    = rdata;
        status_nxt = acpu_pkg::ST_RUNNING;
        state_nxt  = S_FIN;
        if (needs_arg) begin
          pc_nxt    = alu_res.sum;
          state_nxt = S_ARG;
        end else begin
          unique case (rdata)
            acpu_pkg::OPC_NOP: ;
            acpu_pkg::OPC_ADD, acpu_pkg::OPC_SUB: begin
              if (rdata == acpu_pkg::OPC_SUB) begin
                alu_req = '{a: acc_r, b: ~b_r, cin: 1'b1};
                // negating zero adds zero: no carry
                c_nxt   = alu_res.cout && (b_r != '0);
              end else begin
                alu_req = '{a: acc_r, b: b_r, cin: 1'b0};
                c_nxt   = alu_res.cout;
              end
              acc_nxt = alu_res.sum;
              z_nxt   = alu_res.zero;
              n_nxt   = alu_res.neg;
            end
            acpu_pkg::OPC_RET: begin
              if (sp_r == acpu_pkg::BYTE_ONES) begin
                status_nxt = acpu_pkg::ST_UNDERFLOW;
              end else begin
                alu_req      = '{a: sp_r, b: acpu_pkg::BYTE_ONE, cin: 1'b0};
                sp_nxt       = alu_res.sum;
                mem_req.addr = alu_res.sum;
                state_nxt    = S_POP;
              end
            end
            acpu_pkg::OPC_HALT: begin
              halted_nxt = 1'b1;
              status_nxt = acpu_pkg::ST_HALTED;
            end
            default: status_nxt = acpu_pkg::ST_INVALID;
          endcase
        end
      end
      S_ARG: begin
        state_nxt = S_FIN;
        unique case (opc_r)
          acpu_pkg::OPC_LDA_IMM: begin
            acc_nxt = rdata;
            z_nxt   = (rdata == '0);
            n_nxt   = rdata[acpu_pkg::DATA_W-1];
          end
          acpu_pkg::OPC_LDB_IMM: begin
            b_nxt = rdata;
            z_nxt = (rdata == '0);
            n_nxt = rdata[acpu_pkg::DATA_W-1];
          end
          acpu_pkg::OPC_LDA_MEM: begin
            mem_req.addr = rdata;
            state_nxt    = S_LOAD;
          end
          acpu_pkg::OPC_STA: mem_req = '{we: 1'b1, addr: rdata, wdata: acc_r};
          acpu_pkg::OPC_JMP: pc_nxt = rdata;
          acpu_pkg::OPC_JZ: begin
            if (z_r) pc_nxt = rdata;
          end
          acpu_pkg::OPC_CALL: begin
            if (sp_r == '0) begin
              status_nxt = acpu_pkg::ST_OVERFLOW;
            end else begin
              mem_req = '{we: 1'b1, addr: sp_r, wdata: pc_r};
              alu_req = '{a: sp_r, b: acpu_pkg::BYTE_ONES, cin: 1'b0};
              sp_nxt  = alu_res.sum;
              pc_nxt  = rdata;
            end
          end
          default: ;
        endcase
      end
      S_LOAD: begin
        acc_nxt   = rdata;
        z_nxt     = (rdata == '0);
        n_nxt     = rdata[acpu_pkg::DATA_W-1];
        state_nxt = S_FIN;
      end
      S_POP: begin
        pc_nxt    = rdata;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = (out_valid_r && out_stall) || load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      acc_r       <= '0;
      b_r         <= '0;
      sp_r        <= acpu_pkg::SP_RESET;
      z_r         <= 1'b0;
      c_r         <= 1'b0;
      n_r         <= 1'b0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      acc_r       <= acc_nxt;
      b_r         <= b_nxt;
      sp_r        <= sp_nxt;
      z_r         <= z_nxt;
      c_r         <= c_nxt;
      n_r         <= n_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opc_r    <= opc_nxt;
    status_r <= status_nxt;
    if (load_out) begin
      ostat_r   <= status_r;
      opc_out_r <= pc_r;
      oacc_r    <= acc_r;
      ob_r      <= b_r;
      osp_r     <= sp_r;
      oz_r      <= z_r;
      oc_r      <= c_r;
      on_r      <= n_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = ostat_r;
  assign out_prog_counter  = opc_out_r;
  assign out_accumulator   = oacc_r;
  assign out_b_register    = ob_r;
  assign out_stack_pointer = osp_r;
  assign out_zero_flag     = oz_r;
  assign out_carry_flag    = oc_r;
  assign out_negative_flag = on_r;

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("halted state cleared without reset");

  // a new result only comes out of the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && out_stall)) |-> (state_r == S_FIN))
    else $error("result loaded outside finish state");

  // memory writes only for a write transaction, store or call
  a_mem_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> ((state_r == S_ARG) ||
                    (in_accept && (in_operation == acpu_pkg::OPER_WRITE))))
    else $error("unexpected memory write");

  // stack pointer moves only on call or return
  a_sp_moves: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(sp_r)) |-> (($past(state_r) == S_OPC) ||
                                          ($past(state_r) == S_ARG)))
    else $error("stack pointer changed outside call/return");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for accumulator_cpu_step. Small programs go into memory through writes
// and are stepped. A local model of the CPU predicts each result.
// Needs rtl/acpu_pkg.sv and the block's RTL.
module testbench;

  localparam logic [acpu_pkg::OPER_W-1:0] OPER_UNUSED  = 2'd3;
  localparam logic [acpu_pkg::DATA_W-1:0] OPC_BAD      = 8'hFF;
  localparam int unsigned                 CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned                 DRAIN_CYCLES = 20;
  localparam int unsigned                 RANDOM_ITEMS = 1000;
  localparam int unsigned                 REPORT_MAX   = 10;

  typedef struct packed {
    logic [acpu_pkg::OPER_W-1:0] oper;
    logic [acpu_pkg::ADDR_W-1:0] addr;
    logic [acpu_pkg::DATA_W-1:0] wdata;
  } step_req_t;

  typedef struct packed {
    logic [acpu_pkg::STAT_W-1:0] status;
    logic [acpu_pkg::DATA_W-1:0] pc, acc, b_reg, sp;
    logic                        z, c, n;
  } cpu_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [acpu_pkg::OPER_W-1:0] in_operation = acpu_pkg::OPER_EXEC;
  logic [acpu_pkg::ADDR_W-1:0] in_address = '0;
  logic [acpu_pkg::DATA_W-1:0] in_write_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [acpu_pkg::STAT_W-1:0] out_status;
  logic [acpu_pkg::DATA_W-1:0] out_prog_counter, out_accumulator, out_b_register;
  logic [acpu_pkg::DATA_W-1:0] out_stack_pointer;
  logic out_zero_flag, out_carry_flag, out_negative_flag;

  // CPU state as the model sees it
  logic [acpu_pkg::DATA_W-1:0] cpu_mem [acpu_pkg::MEM_DEPTH];
  logic [acpu_pkg::DATA_W-1:0] cpu_pc, cpu_acc, cpu_b, cpu_sp;
  logic                        cpu_z, cpu_c, cpu_n, cpu_halted;

  step_req_t   pending_steps [$];
  cpu_view_t   expected_views [$];
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        took_step = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 200;
  logic        calm = 1'b0;
  int unsigned calm_left = 0;

  accumulator_cpu_step DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_address        (in_address),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_prog_counter  (out_prog_counter),
    .out_accumulator   (out_accumulator),
    .out_b_register    (out_b_register),
    .out_stack_pointer (out_stack_pointer),
    .out_zero_flag     (out_zero_flag),
    .out_carry_flag    (out_carry_flag),
    .out_negative_flag (out_negative_flag)
  );

  always #10 clk = ~clk;

  function automatic logic has_operand(logic [acpu_pkg::DATA_W-1:0] opc);
    return opc inside {acpu_pkg::OPC_LDA_IMM, acpu_pkg::OPC_LDA_MEM, acpu_pkg::OPC_STA,
                       acpu_pkg::OPC_LDB_IMM, acpu_pkg::OPC_JMP, acpu_pkg::OPC_JZ,
                       acpu_pkg::OPC_CALL};
  endfunction

  function automatic logic [acpu_pkg::DATA_W-1:0] fetch_byte();
    fetch_byte = cpu_mem[cpu_pc];
    cpu_pc = cpu_pc + acpu_pkg::BYTE_ONE;
  endfunction

  function automatic void set_zn(logic [acpu_pkg::DATA_W-1:0] v);
    cpu_z = (v == '0);
    cpu_n = v[acpu_pkg::DATA_W-1];
  endfunction

  function automatic cpu_view_t cpu_step(logic [acpu_pkg::OPER_W-1:0] oper,
                                         logic [acpu_pkg::ADDR_W-1:0] addr,
                                         logic [acpu_pkg::DATA_W-1:0] wdata);
    cpu_view_t                   v;
    logic [acpu_pkg::DATA_W-1:0] opc, arg, addend;
    logic [acpu_pkg::DATA_W:0]   sum;
    v.status = acpu_pkg::ST_RUNNING;
    if (oper == acpu_pkg::OPER_EXEC && cpu_halted) begin
      v.status = acpu_pkg::ST_HALTED;
    end else if (oper == acpu_pkg::OPER_EXEC) begin
      opc = fetch_byte();
      arg = '0;
      if (has_operand(opc)) arg = fetch_byte();
      case (opc)
        acpu_pkg::OPC_NOP: ;
        acpu_pkg::OPC_LDA_IMM: begin
          cpu_acc = arg;
          set_zn(cpu_acc);
        end
        acpu_pkg::OPC_LDA_MEM: begin
          cpu_acc = cpu_mem[arg];
          set_zn(cpu_acc);
        end
        acpu_pkg::OPC_STA: cpu_mem[arg] = cpu_acc;
        acpu_pkg::OPC_LDB_IMM: begin
          cpu_b = arg;
          set_zn(cpu_b);
        end
        acpu_pkg::OPC_ADD, acpu_pkg::OPC_SUB: begin
          // subtract adds the two's complement, so B == 0 leaves carry clear
          addend = (opc == acpu_pkg::OPC_ADD) ? cpu_b : ~cpu_b + acpu_pkg::BYTE_ONE;
          sum = {1'b0, cpu_acc} + {1'b0, addend};
          cpu_acc = sum[acpu_pkg::DATA_W-1:0];
          cpu_c = sum[acpu_pkg::DATA_W];
          set_zn(cpu_acc);
        end
        acpu_pkg::OPC_JMP: cpu_pc = arg;
        acpu_pkg::OPC_JZ: if (cpu_z) cpu_pc = arg;
        acpu_pkg::OPC_CALL: begin
          if (cpu_sp == '0) begin
            v.status = acpu_pkg::ST_OVERFLOW;
          end else begin
            cpu_mem[cpu_sp] = cpu_pc;
            cpu_sp = cpu_sp - acpu_pkg::BYTE_ONE;
            cpu_pc = arg;
          end
        end
        acpu_pkg::OPC_RET: begin
          if (cpu_sp == acpu_pkg::SP_RESET) begin
            v.status = acpu_pkg::ST_UNDERFLOW;
          end else begin
            cpu_sp = cpu_sp + acpu_pkg::BYTE_ONE;
            cpu_pc = cpu_mem[cpu_sp];
          end
        end
        acpu_pkg::OPC_HALT: begin
          cpu_halted = 1'b1;
          v.status = acpu_pkg::ST_HALTED;
        end
        default: v.status = acpu_pkg::ST_INVALID;
      endcase
    end else begin
      if (oper == acpu_pkg::OPER_WRITE) cpu_mem[addr] = wdata;
      else if (oper == acpu_pkg::OPER_SETPC) cpu_pc = addr;
      if (cpu_halted) v.status = acpu_pkg::ST_HALTED;
    end
    v.pc = cpu_pc;
    v.acc = cpu_acc;
    v.b_reg = cpu_b;
    v.sp = cpu_sp;
    v.z = cpu_z;
    v.c = cpu_c;
    v.n = cpu_n;
    return v;
  endfunction

  // mostly no idling, sometimes a short gap, rarely a long stretch
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic [acpu_pkg::DATA_W-1:0] rand_byte();
    logic [acpu_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 8'h00;
      1: v = 8'hFF;
      2: v = 8'h80;
      3: v = 8'h7F;
      default: v = 8'($urandom);
    endcase
    // a stray halt byte would freeze the CPU for the rest of the run
    if (v == acpu_pkg::OPC_HALT) v = acpu_pkg::OPC_NOP;
    return v;
  endfunction

  task automatic queue_step(logic [acpu_pkg::OPER_W-1:0] oper,
                            logic [acpu_pkg::ADDR_W-1:0] addr,
                            logic [acpu_pkg::DATA_W-1:0] wdata);
    pending_steps.push_back('{oper, addr, wdata});
    queued_cnt++;
  endtask

  // model state is current once every queued transaction has been accepted
  task automatic wait_accepted();
    while (accepted_cnt != queued_cnt) @(posedge clk);
  endtask

  task automatic log_mismatch(string why, cpu_view_t want, cpu_view_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display({"%0t result %0d %s: expected st=%0d pc=%02h a=%02h b=%02h sp=%02h zcn=%b%b%b,",
                " got st=%0d pc=%02h a=%02h b=%02h sp=%02h zcn=%b%b%b"},
               $time, checked_cnt, why, want.status, want.pc, want.acc, want.b_reg, want.sp,
               want.z, want.c, want.n, got.status, got.pc, got.acc, got.b_reg, got.sp,
               got.z, got.c, got.n);
  endtask

  always @(negedge clk) begin
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(100, 400);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // driver: a held transaction stays put until accepted
  always @(negedge clk) begin : step_driver
    step_req_t nxt;
    if (rst_n && (!in_valid || took_step)) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_steps.size() != 0) begin
        nxt = pending_steps.pop_front();
        in_operation <= nxt.oper;
        in_address <= nxt.addr;
        in_write_data <= nxt.wdata;
        in_valid <= 1'b1;
        send_gap <= calm ? 0 : pick_idle();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    took_step <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_views.push_back(cpu_step(in_operation, in_address, in_write_data));
      accepted_cnt++;
    end
  end

  // receiver stall, with a long hold-off now and then so the block backs up
  always @(negedge clk) begin : result_stall
    int unsigned n;
    if (rst_n) begin
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (checked_cnt >= next_hold_at) begin
        out_stall <= 1'b1;
        hold_left <= $urandom_range(150, 250);
        next_hold_at <= next_hold_at + 700;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        n = calm ? 0 : pick_idle();
        out_stall <= (n != 0);
        stall_left <= (n != 0) ? n - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    cpu_view_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_prog_counter, out_accumulator, out_b_register, out_stack_pointer,
              out_zero_flag, out_carry_flag, out_negative_flag};
      if (expected_views.size() == 0) begin
        log_mismatch("arrived with nothing expected", '0, got);
      end else begin
        want = expected_views.pop_front();
        if (got !== want) log_mismatch("differs", want, got);
      end
      checked_cnt++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [acpu_pkg::DATA_W-1:0] boot_code [13];
    logic [acpu_pkg::DATA_W-1:0] opc, byte_v;
    logic [acpu_pkg::ADDR_W-1:0] a;
    int unsigned                 made, base, n_ops, k;

    foreach (cpu_mem[i]) cpu_mem[i] = '0;
    cpu_pc = '0;
    cpu_acc = '0;
    cpu_b = '0;
    cpu_sp = acpu_pkg::SP_RESET;
    cpu_z = 1'b0;
    cpu_c = 1'b0;
    cpu_n = 1'b0;
    cpu_halted = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ret on an empty stack, loads with sign bit, add with carry out, sub, a bad opcode,
    // call and return, jump back to the start
    boot_code = '{acpu_pkg::OPC_RET, acpu_pkg::OPC_LDA_IMM, 8'h80, acpu_pkg::OPC_LDB_IMM,
                  8'hFF, acpu_pkg::OPC_ADD, acpu_pkg::OPC_SUB, OPC_BAD, acpu_pkg::OPC_CALL,
                  8'h0C, acpu_pkg::OPC_JMP, 8'h00, acpu_pkg::OPC_RET};
    queue_step(OPER_UNUSED, 8'hFF, 8'hFF);
    foreach (boot_code[i]) queue_step(acpu_pkg::OPER_WRITE, 8'(i), boot_code[i]);
    repeat (9) queue_step(acpu_pkg::OPER_EXEC, 8'($urandom), 8'($urandom));
    // the call left its return address in the top stack slot; run it as a ret
    queue_step(acpu_pkg::OPER_SETPC, 8'hFF, 8'h00);
    queue_step(acpu_pkg::OPER_EXEC, 8'h00, 8'h00);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          queue_step(2'($urandom_range(0, 3)), 8'($urandom), rand_byte());
          made++;
        end
      end else begin
        wait_accepted();
        for (k = 0; k < acpu_pkg::MEM_DEPTH; k++)
          if (cpu_mem[k] == acpu_pkg::OPC_HALT) begin
            queue_step(acpu_pkg::OPER_WRITE, 8'(k), acpu_pkg::OPC_NOP);
            made++;
          end
        base = $urandom_range(0, 255);
        a = 8'(base);
        n_ops = $urandom_range(3, 8);
        repeat (n_ops) begin
          if ($urandom_range(0, 24) == 0)
            opc = 8'($urandom_range(acpu_pkg::OPC_HALT + 1, 255));
          else
            opc = 8'($urandom_range(acpu_pkg::OPC_NOP, acpu_pkg::OPC_RET));
          queue_step(acpu_pkg::OPER_WRITE, a, opc);
          a = a + acpu_pkg::BYTE_ONE;
          made++;
          if (has_operand(opc)) begin
            if (opc inside {acpu_pkg::OPC_JMP, acpu_pkg::OPC_JZ, acpu_pkg::OPC_CALL} &&
                $urandom_range(0, 3) != 0)
              byte_v = 8'(base + $urandom_range(0, 2 * n_ops + 1));
            else
              byte_v = rand_byte();
            queue_step(acpu_pkg::OPER_WRITE, a, byte_v);
            a = a + acpu_pkg::BYTE_ONE;
            made++;
          end
        end
        queue_step(acpu_pkg::OPER_SETPC, 8'(base), rand_byte());
        made++;
        repeat ($urandom_range(4, 3 * n_ops)) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_step(($urandom_range(0, 1) != 0) ? acpu_pkg::OPER_WRITE : OPER_UNUSED,
                       8'($urandom), rand_byte());
            made++;
          end
          queue_step(acpu_pkg::OPER_EXEC, 8'($urandom), 8'($urandom));
          made++;
        end
      end
    end

    // call to itself until the stack runs out, then pop a few entries back
    wait_accepted();
    queue_step(acpu_pkg::OPER_WRITE, 8'h00, acpu_pkg::OPC_CALL);
    queue_step(acpu_pkg::OPER_WRITE, 8'h01, 8'h00);
    queue_step(acpu_pkg::OPER_SETPC, 8'h00, rand_byte());
    repeat (int'(cpu_sp) + 1) queue_step(acpu_pkg::OPER_EXEC, 8'($urandom), 8'($urandom));
    queue_step(acpu_pkg::OPER_WRITE, 8'h40, acpu_pkg::OPC_RET);
    repeat (8) begin
      queue_step(acpu_pkg::OPER_SETPC, 8'h40, rand_byte());
      queue_step(acpu_pkg::OPER_EXEC, 8'($urandom), 8'($urandom));
    end

    // halt is sticky, so it comes last; writes and pc loads still go through
    queue_step(acpu_pkg::OPER_WRITE, 8'h50, acpu_pkg::OPC_HALT);
    queue_step(acpu_pkg::OPER_SETPC, 8'h50, 8'h00);
    queue_step(acpu_pkg::OPER_EXEC, 8'h00, 8'h00);
    queue_step(acpu_pkg::OPER_EXEC, 8'hFF, 8'hFF);
    queue_step(acpu_pkg::OPER_WRITE, 8'h50, acpu_pkg::OPC_NOP);
    queue_step(acpu_pkg::OPER_SETPC, 8'h50, 8'h00);
    queue_step(acpu_pkg::OPER_EXEC, 8'h00, 8'h00);
    queue_step(OPER_UNUSED, 8'h00, 8'h00);

    while (accepted_cnt != queued_cnt || expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
